### design/sha1_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types and constants for the SHA-1 message digest block.
// ----------------------------------------------------------------------------
package sha1_pkg;

	localparam logic [31:0] K0 = 32'h5a827999;
	localparam logic [31:0] K1 = 32'h6ed9eba1;
	localparam logic [31:0] K2 = 32'h8f1bbcdc;
	localparam logic [31:0] K3 = 32'hca62c1d6;

	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hefcdab89;
	localparam logic [31:0] IV2 = 32'h98badcfe;
	localparam logic [31:0] IV3 = 32'h10325476;
	localparam logic [31:0] IV4 = 32'hc3d2e1f0;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;
	localparam logic [6:0] LAST_ROUND = 7'd79;
	localparam logic [2:0] LAST_WORD_IDX = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FOLD,
		ST_PAD,
		ST_EMIT
	} state_t;

	// Byte source for the block buffer.
	typedef enum logic [1:0] {
		BSRC_DATA,
		BSRC_PAD,
		BSRC_ZERO,
		BSRC_LEN
	} bsrc_t;

	// Controller to datapath.
	typedef struct packed {
		logic  put_byte;
		bsrc_t bsrc;
		logic  add_bits;
		logic  start_rounds;
		logic  do_round;
		logic  fold;
		logic  restart;
		logic  latch_len;
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic       block_full;   // put_byte fills the last slot
		logic [5:0] byte_pos;
		logic       last_round;
	} dp_sts_t;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
		rotl = (v << n) | (v >> (32 - n));
	endfunction

endpackage
`default_nettype wire

### design/sha1_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_datapath
// Block buffer, bit counter, chaining words and one SHA-1 round per cycle.
// ----------------------------------------------------------------------------
module sha1_datapath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sha1_pkg::dp_cmd_t cmd,
	input  wire logic [7:0]        data_byte,
	input  wire logic [2:0]        out_idx,
	output sha1_pkg::dp_sts_t      sts,
	output logic [31:0]            out_word
);

	logic [31:0] blk_q [16];
	logic [31:0] h_q [5];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [63:0] bits_q;
	logic [63:0] len_q;
	logic [5:0]  pos_q;
	logic [6:0]  rnd_q;
	logic [2:0]  len_cnt;
	logic [7:0]  byte_in;
	logic [31:0] wt, wnew, f, k, tmp;

	// Byte selection; length bytes go out most significant first
	assign len_cnt = pos_q[2:0];
	always_comb begin
		case (cmd.bsrc)
			sha1_pkg::BSRC_DATA: byte_in = data_byte;
			sha1_pkg::BSRC_PAD:  byte_in = sha1_pkg::PAD_BYTE;
			sha1_pkg::BSRC_ZERO: byte_in = 8'h00;
			sha1_pkg::BSRC_LEN:  byte_in = len_q[63 - 8*len_cnt -: 8];
			default:             byte_in = 8'h00;
		endcase
	end

	// Round logic; the schedule expands in place over the circular buffer
	assign wnew = sha1_pkg::rotl(blk_q[rnd_q[3:0] + 4'd13] ^ blk_q[rnd_q[3:0] + 4'd8]
		^ blk_q[rnd_q[3:0] + 4'd2] ^ blk_q[rnd_q[3:0]], 1);
	assign wt = (rnd_q < 7'd16) ? blk_q[rnd_q[3:0]] : wnew;
	always_comb begin
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = sha1_pkg::K0;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = sha1_pkg::K1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = sha1_pkg::K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = sha1_pkg::K3;
		end
	end
	assign tmp = sha1_pkg::rotl(a_q, 5) + f + e_q + k + wt;

	// Block buffer, written by bytes or by schedule expansion
	always_ff @(posedge clk) begin
		if (cmd.put_byte) begin
			blk_q[pos_q[5:2]][31 - 8*pos_q[1:0] -: 8] <= byte_in;
		end else if (cmd.do_round && rnd_q >= 7'd16) begin
			blk_q[rnd_q[3:0]] <= wnew;
		end
	end

	// Working variables and length snapshot
	always_ff @(posedge clk) begin
		if (cmd.start_rounds) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (cmd.do_round) begin
			a_q <= tmp;
			b_q <= a_q;
			c_q <= sha1_pkg::rotl(b_q, 30);
			d_q <= c_q;
			e_q <= d_q;
		end
		if (cmd.latch_len) begin
			len_q <= bits_q;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q[0] <= sha1_pkg::IV0;
			h_q[1] <= sha1_pkg::IV1;
			h_q[2] <= sha1_pkg::IV2;
			h_q[3] <= sha1_pkg::IV3;
			h_q[4] <= sha1_pkg::IV4;
			bits_q <= '0;
			pos_q  <= '0;
			rnd_q  <= '0;
		end else begin
			if (cmd.restart) begin
				h_q[0] <= sha1_pkg::IV0;
				h_q[1] <= sha1_pkg::IV1;
				h_q[2] <= sha1_pkg::IV2;
				h_q[3] <= sha1_pkg::IV3;
				h_q[4] <= sha1_pkg::IV4;
				bits_q <= '0;
				pos_q  <= '0;
			end else begin
				if (cmd.fold) begin
					h_q[0] <= h_q[0] + a_q;
					h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q;
					h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
				end
				if (cmd.add_bits) begin
					bits_q <= bits_q + 64'd8;
				end
				if (cmd.put_byte) begin
					pos_q <= pos_q + 6'd1;
				end
			end
			if (cmd.start_rounds) begin
				rnd_q <= '0;
			end else if (cmd.do_round) begin
				rnd_q <= rnd_q + 7'd1;
			end
		end
	end

	assign sts.block_full = cmd.put_byte && (pos_q == 6'd63);
	assign sts.byte_pos   = pos_q;
	assign sts.last_round = (rnd_q == sha1_pkg::LAST_ROUND);
	assign out_word       = h_q[out_idx];

endmodule
`default_nettype wire

### design/sha1_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_ctrl
// Sequencer: byte intake, padding, compression rounds and digest output.
// ----------------------------------------------------------------------------
module sha1_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              byte_valid,
	input  wire logic              end_of_message,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [2:0]             out_idx,
	output sha1_pkg::dp_cmd_t      cmd,
	input  wire sha1_pkg::dp_sts_t sts
);

	sha1_pkg::state_t state_q, state_d;
	logic closing_q, closing_d;      // message closed, digest pending
	logic padded_q, padded_d;        // 0x80 byte already written
	logic len_phase_q, len_phase_d;  // zero fill done, length bytes go next
	logic [2:0] idx_q, idx_d;
	logic acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sha1_pkg::ST_IDLE;
			closing_q   <= 1'b0;
			padded_q    <= 1'b0;
			len_phase_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			state_q     <= state_d;
			closing_q   <= closing_d;
			padded_q    <= padded_d;
			len_phase_q <= len_phase_d;
			idx_q       <= idx_d;
		end
	end

	assign out_idx = idx_q;
	assign acc     = in_valid && in_ready;

	always_comb begin
		state_d     = state_q;
		closing_d   = closing_q;
		padded_d    = padded_q;
		len_phase_d = len_phase_q;
		idx_d       = idx_q;
		cmd         = '0;
		cmd.bsrc    = sha1_pkg::BSRC_DATA;
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		case (state_q)
			sha1_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (acc) begin
					if (byte_valid) begin
						cmd.put_byte = 1'b1;
						cmd.add_bits = 1'b1;
					end
					if (end_of_message) begin
						closing_d = 1'b1;
						state_d   = sha1_pkg::ST_PAD;
					end
					if (byte_valid && sts.block_full) begin
						cmd.start_rounds = 1'b1;
						state_d          = sha1_pkg::ST_ROUND;
					end
				end
			end
			sha1_pkg::ST_ROUND: begin
				cmd.do_round = 1'b1;
				if (sts.last_round) begin
					state_d = sha1_pkg::ST_FOLD;
				end
			end
			sha1_pkg::ST_FOLD: begin
				cmd.fold = 1'b1;
				state_d  = closing_q ? sha1_pkg::ST_PAD : sha1_pkg::ST_IDLE;
				if (closing_q && len_phase_q) begin
					// length already written: block was final
					state_d     = sha1_pkg::ST_EMIT;
					idx_d       = '0;
					closing_d   = 1'b0;
					padded_d    = 1'b0;
					len_phase_d = 1'b0;
				end
			end
			sha1_pkg::ST_PAD: begin
				// first the 0x80 byte, then zeros up to byte 56, then the length
				cmd.put_byte = 1'b1;
				if (!padded_q) begin
					cmd.bsrc      = sha1_pkg::BSRC_PAD;
					cmd.latch_len = 1'b1;
					padded_d      = 1'b1;
					if (sts.byte_pos == sha1_pkg::LEN_POS - 6'd1) begin
						len_phase_d = 1'b1;
					end
				end else if (len_phase_q) begin
					cmd.bsrc = sha1_pkg::BSRC_LEN;
				end else begin
					cmd.bsrc = sha1_pkg::BSRC_ZERO;
					if (sts.byte_pos == sha1_pkg::LEN_POS - 6'd1) begin
						len_phase_d = 1'b1;
					end
				end
				if (sts.block_full) begin
					cmd.start_rounds = 1'b1;
					state_d          = sha1_pkg::ST_ROUND;
				end
			end
			sha1_pkg::ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					idx_d = idx_q + 3'd1;
					if (idx_q == sha1_pkg::LAST_WORD_IDX) begin
						cmd.restart = 1'b1;
						idx_d       = '0;
						state_d     = sha1_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = sha1_pkg::ST_IDLE;
		endcase
		// A fold outside a closing message returns to idle.
		if (state_q == sha1_pkg::ST_FOLD && !closing_q) begin
			state_d = sha1_pkg::ST_IDLE;
		end
	end

endmodule
`default_nettype wire

### design/sha1_message_digest.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_message_digest
// SHA-1 over a byte stream, five digest words per message.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): data_byte with byte_valid, and
// end_of_message to close the message. The 64th byte of a block starts the
// compression rounds and then the fold, during which in_ready is low. One
// compression round per cycle sets the rate. End of message pads one byte
// per cycle to the 64-byte boundary (plus a second block when the length
// does not fit) and runs the final compressions. It then presents five
// results h0..h4 on the output channel (out_valid/out_ready), word_index
// counting 0..4 and last_word on the fifth. If the receiver stalls, the
// word holds and no input is taken until all five words are delivered. The
// chaining words then reload the initial vector for the next message. Reset
// returns the block to idle with the initial vector, zero bit count and
// empty block.
// ----------------------------------------------------------------------------
module sha1_message_digest (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        byte_valid,
	input  wire logic        end_of_message,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_word
);

	sha1_pkg::dp_cmd_t cmd;
	sha1_pkg::dp_sts_t sts;
	logic [2:0]        idx;

	sha1_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.byte_valid     (byte_valid),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_idx        (idx),
		.cmd            (cmd),
		.sts            (sts)
	);

	sha1_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.data_byte (data_byte),
		.out_idx   (idx),
		.sts       (sts),
		.out_word  (digest_word)
	);

	assign word_index = idx;
	assign last_word  = (idx == sha1_pkg::LAST_WORD_IDX);

`ifndef ASSERT_OFF
	// No input transaction while a digest is being delivered
	a_no_in_during_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken during output");

	// Word index stays in range
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (word_index <= sha1_pkg::LAST_WORD_IDX))
		else $error("word index out of range");

	// Rounds never overlap a byte write
	a_round_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_round |-> !cmd.put_byte) else $error("round with byte write");

	// After the last word is taken, the block returns to accepting input
	a_last_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_word) |=> in_ready)
		else $error("not idle after digest");
`endif

endmodule
`default_nettype wire
